// ===== hdl/bcd_pkg.sv =====
`default_nettype none

package bcd_pkg;

  localparam int unsigned EvW      = 7;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned CountW   = 4;
  localparam int unsigned TicksW   = 10;
  localparam int unsigned TickCntW = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [TickCntW-1:0] TickMax = '1;

  // event codes; all but EV_NONE are also bit positions in the event masks
  localparam logic [CodeW-1:0] EV_DOWN   = 3'd0;
  localparam logic [CodeW-1:0] EV_UP     = 3'd1;
  localparam logic [CodeW-1:0] EV_REPEAT = 3'd2;
  localparam logic [CodeW-1:0] EV_SINGLE = 3'd3;
  localparam logic [CodeW-1:0] EV_DOUBLE = 3'd4;
  localparam logic [CodeW-1:0] EV_LSTART = 3'd5;
  localparam logic [CodeW-1:0] EV_LHOLD  = 3'd6;
  localparam logic [CodeW-1:0] EV_NONE   = 3'd7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LEVEL   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TICKS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_TICKS    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LONG_TICKS     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_LIMIT   = 3'd4;

  localparam logic [CountW-1:0] DebounceReset    = 4'd3;
  localparam logic [TicksW-1:0] ShortReset       = 10'd60;
  localparam logic [TicksW-1:0] LongReset        = 10'd200;
  localparam logic [CountW-1:0] RepeatLimitReset = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESS   = 3'd1,
    ST_RELEASE = 3'd2,
    ST_REPEAT  = 3'd3,
    ST_LONG    = 3'd4
  } state_e;

  typedef struct packed {
    logic [EvW-1:0]    raised_events;
    logic [EvW-1:0]    pending_events;
    logic [CodeW-1:0]  last_event;
    logic [CountW-1:0] repeat_count;
    logic              pressed;
  } res_t;

  function automatic logic [EvW-1:0] ev_bit(input logic [CodeW-1:0] code);
    ev_bit = EvW'(1) << code;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/button_click_detector_top.sv =====
`default_nettype none
// Button click detector: debounce, click counting and long-press events for
// one button, one item per scan tick.
// Input channel (in_valid_i / in_stall_o): raw_level_i, clear_pending_i. An
// item is taken when valid is high and stall is low.
// Output channel (out_valid_o / out_stall_i): one result item per input item,
// in order: raised events, pending mask, last event, repeat count, pressed.
// The state update and result are computed in the cycle the item is taken and
// the result is registered at that edge. Throughput is one item per cycle while
// in_stall_o is low; the per-tick state update is a single pass of logic.
// Results go into a two-entry output buffer, so in_stall_o is a registered
// flag that rises only when both entries hold results the receiver has not
// taken. While out_stall_i is high results simply stay in the buffer.
// Configuration (cfg_valid_i / cfg_ready_o, always ready) writes registers
// 0 active level, 1 debounce ticks, 2 short ticks, 3 long ticks, 4 repeat
// limit; other indexes are ignored. Write only while the block is idle.
// Writing the active level sets the debounced level to its inverse.
// Reset returns all registers to defaults, the machine to idle and empties
// the output buffer.

module button_click_detector_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          raw_level_i,
  input  wire                          clear_pending_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [bcd_pkg::EvW-1:0]      raised_events_o,
  output logic [bcd_pkg::EvW-1:0]      pending_events_o,
  output logic [bcd_pkg::CodeW-1:0]    last_event_o,
  output logic [bcd_pkg::CountW-1:0]   repeat_count_o,
  output logic                         pressed_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [bcd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [bcd_pkg::CfgDataW-1:0] cfg_data_i
);
  import bcd_pkg::*;

  // configuration
  logic              active_level_q;
  logic [CountW-1:0] debounce_ticks_q;
  logic [TicksW-1:0] short_ticks_q;
  logic [TicksW-1:0] long_ticks_q;
  logic [CountW-1:0] repeat_limit_q;

  // state
  state_e              state_q, state_d;
  logic [TickCntW-1:0] tick_q, tick_d;
  logic [CountW-1:0]   deb_cnt_q, deb_cnt_d;
  logic                deb_lvl_q, deb_lvl_d;
  logic [CountW-1:0]   click_q, click_d;
  logic [CodeW-1:0]    sticky_q, sticky_d;
  logic [EvW-1:0]      pending_q, pending_d;

  logic                accept;
  logic                cfg_we;
  logic                act;
  logic [EvW-1:0]      raised;
  logic [EvW-1:0]      pend_now;
  logic [CountW-1:0]   deb_inc;
  logic [TickCntW-1:0] tick_inc;
  res_t                res;
  res_t                head;
  logic                buf_full;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = buf_full;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    click_d   = click_q;
    sticky_d  = sticky_q;
    raised    = '0;
    deb_lvl_d = deb_lvl_q;
    deb_cnt_d = '0;

    tick_inc = ((state_q != ST_IDLE) && (tick_q < TickMax)) ? tick_q + 1'b1 : tick_q;
    tick_d   = tick_inc;

    deb_inc = deb_cnt_q + 1'b1;
    if (raw_level_i != deb_lvl_q) begin
      // a debounce setting of zero accepts on the first differing tick
      if (deb_inc >= debounce_ticks_q) begin
        deb_lvl_d = raw_level_i;
        deb_cnt_d = '0;
      end else begin
        deb_cnt_d = deb_inc;
      end
    end

    act = (deb_lvl_d == active_level_q);

    unique case (state_q)
      ST_IDLE: begin
        if (act) begin
          sticky_d = EV_DOWN;
          raised   = ev_bit(EV_DOWN);
          tick_d   = '0;
          click_d  = CountW'(1);
          state_d  = ST_PRESS;
        end else begin
          sticky_d = EV_NONE;
        end
      end
      ST_PRESS: begin
        if (!act) begin
          sticky_d = EV_UP;
          raised   = ev_bit(EV_UP);
          tick_d   = '0;
          state_d  = ST_RELEASE;
        end else if (tick_inc > TickCntW'(long_ticks_q)) begin
          sticky_d = EV_LSTART;
          raised   = ev_bit(EV_LSTART);
          state_d  = ST_LONG;
        end
      end
      ST_RELEASE: begin
        if (act) begin
          sticky_d = EV_DOWN;
          raised   = ev_bit(EV_DOWN) | ev_bit(EV_REPEAT);
          if (click_q < repeat_limit_q) begin
            click_d = click_q + 1'b1;
          end
          tick_d  = '0;
          state_d = ST_REPEAT;
        end else if (tick_inc > TickCntW'(short_ticks_q)) begin
          // three or more clicks end the sequence silently
          if (click_q == CountW'(1)) begin
            sticky_d = EV_SINGLE;
            raised   = ev_bit(EV_SINGLE);
          end else if (click_q == CountW'(2)) begin
            sticky_d = EV_DOUBLE;
            raised   = ev_bit(EV_DOUBLE);
          end
          state_d = ST_IDLE;
        end
      end
      ST_REPEAT: begin
        if (!act) begin
          sticky_d = EV_UP;
          raised   = ev_bit(EV_UP);
          if (tick_inc < TickCntW'(short_ticks_q)) begin
            tick_d  = '0;
            state_d = ST_RELEASE;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (tick_inc > TickCntW'(short_ticks_q)) begin
          state_d = ST_PRESS;
        end
      end
      ST_LONG: begin
        if (act) begin
          sticky_d = EV_LHOLD;
          raised   = ev_bit(EV_LHOLD);
        end else begin
          sticky_d = EV_UP;
          raised   = ev_bit(EV_UP);
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    pend_now  = pending_q | raised;
    pending_d = clear_pending_i ? '0 : pend_now;

    res.raised_events  = raised;
    res.pending_events = pend_now;
    res.last_event     = sticky_d;
    res.repeat_count   = click_d;
    res.pressed        = act;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q   <= 1'b0;
      debounce_ticks_q <= DebounceReset;
      short_ticks_q    <= ShortReset;
      long_ticks_q     <= LongReset;
      repeat_limit_q   <= RepeatLimitReset;
      state_q          <= ST_IDLE;
      tick_q           <= '0;
      deb_cnt_q        <= '0;
      deb_lvl_q        <= 1'b1;
      click_q          <= '0;
      sticky_q         <= EV_NONE;
      pending_q        <= '0;
    end else begin
      if (accept) begin
        state_q   <= state_d;
        tick_q    <= tick_d;
        deb_cnt_q <= deb_cnt_d;
        deb_lvl_q <= deb_lvl_d;
        click_q   <= click_d;
        sticky_q  <= sticky_d;
        pending_q <= pending_d;
      end
      if (cfg_we) begin
        unique case (cfg_index_i)
          CFG_ACTIVE_LEVEL: begin
            active_level_q <= cfg_data_i[0];
            deb_lvl_q      <= ~cfg_data_i[0];
          end
          CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data_i[CountW-1:0];
          CFG_SHORT_TICKS:    short_ticks_q    <= cfg_data_i[TicksW-1:0];
          CFG_LONG_TICKS:     long_ticks_q     <= cfg_data_i[TicksW-1:0];
          CFG_REPEAT_LIMIT:   repeat_limit_q   <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  bcd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (head)
  );

  assign raised_events_o  = head.raised_events;
  assign pending_events_o = head.pending_events;
  assign last_event_o     = head.last_event;
  assign repeat_count_o   = head.repeat_count;
  assign pressed_o        = head.pressed;

  // back-pressure only when results are waiting
  a_stall_has_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output buffer");

  a_raised_in_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((raised_events_o & ~pending_events_o) == '0))
    else $error("raised event missing from pending mask");

  a_down_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (raised_events_o[EV_DOWN] || raised_events_o[EV_LHOLD])) |-> pressed_o)
    else $error("press event without pressed level");

  a_up_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && raised_events_o[EV_UP]) |-> !pressed_o)
    else $error("release event while pressed");

endmodule

`default_nettype wire

// ===== hdl/bcd_out_buf.sv =====
`default_nettype none

module bcd_out_buf (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  wire bcd_pkg::res_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  output bcd_pkg::res_t out_data_o
);
  import bcd_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire
